// File: design/asa_pkg.sv
package asa_pkg;

    // Field widths of the word formats
    localparam int ADDR_W = 13;
    localparam int OP_W   = 2;
    localparam int LOG2_W = 4;
    localparam int AOFF_W = 12;

    // Width of the internal alignment arithmetic.
    // Covers top + offset + mask + size with the widest alignment field.
    localparam int CALC_W = 17;

    // Reset value of the buffer_size register
    localparam logic [ADDR_W-1:0] BUFFER_SIZE_RESET = 13'd4096;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;   // capture input word, start header read
        logic finish;   // commit top/header, load output register
    } asa_cmd_t;

endpackage

// File: design/asa_ctrl.sv
module asa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output asa_pkg::asa_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_FINISH = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    // Output slot can take a new word when empty or being drained
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.accept = s_valid && (state_reg == ST_IDLE);
    assign cmd.finish = (state_reg == ST_FINISH) && out_free;
    assign m_valid    = m_valid_reg;

    // Next state and output valid
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/asa_datapath.sv
module asa_datapath #(
    parameter int BUFFER_BYTES = 4096,
    parameter int HEADER_BYTES = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  asa_pkg::asa_cmd_t            cmd,
    input  logic                         cfg_we,
    input  logic [asa_pkg::ADDR_W-1:0]   cfg_wdata,
    input  logic [asa_pkg::OP_W-1:0]     s_operation,
    input  logic [asa_pkg::ADDR_W-1:0]   s_request_bytes,
    input  logic [asa_pkg::LOG2_W-1:0]   s_alignment_log2,
    input  logic [asa_pkg::AOFF_W-1:0]   s_align_offset,
    input  logic [asa_pkg::ADDR_W-1:0]   s_release_address,
    output logic [asa_pkg::ADDR_W-1:0]   m_granted_address,
    output logic                         m_granted,
    output logic [asa_pkg::ADDR_W-1:0]   m_stack_top
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = asa_pkg::CALC_W;
    localparam int DW = asa_pkg::ADDR_W;
    localparam logic [CW-1:0] HDR      = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] BUF_LAST = CW'(BUFFER_BYTES);
    localparam logic [DW-1:0] LIMIT_RESET =
        (BUFFER_BYTES < 4096) ? DW'(BUFFER_BYTES) : asa_pkg::BUFFER_SIZE_RESET;

    // Header memory: saved old top, indexed by block start
    logic [DW-1:0] hdr_mem [BUFFER_BYTES];

    logic [DW-1:0]             limit_reg;
    logic [DW-1:0]             top_reg, top_next;
    logic [asa_pkg::OP_W-1:0]  op_reg;
    logic [CW-1:0]             aligned_reg;
    logic [CW-1:0]             off_reg;
    logic [CW-1:0]             aoff_reg;
    logic [CW-1:0]             delta_reg;
    logic                      req_zero_reg;
    logic                      free_ok_reg;
    logic [DW-1:0]             hdr_rd_reg;
    logic [DW-1:0]             addr_out_reg;
    logic                      granted_out_reg;
    logic [DW-1:0]             top_out_reg;

    // Front-end arithmetic on the incoming word
    logic [CW-1:0] off_in, mask_in, sum_in, rel_idx;
    logic          free_ok_in;

    assign off_in     = CW'(s_align_offset) + HDR;
    assign mask_in    = (CW'(1) << s_alignment_log2) - CW'(1);
    assign sum_in     = CW'(top_reg) + off_in + mask_in;
    assign rel_idx    = CW'(s_release_address) - HDR;
    assign free_ok_in = (CW'(s_release_address) >= HDR) && (rel_idx < BUF_LAST);

    // Back-end: block start, new top and fit check
    logic [CW-1:0] start_c, new_top_c, user_c;
    logic          fit_c, do_alloc;
    logic          granted_c;
    logic [DW-1:0] addr_c;

    assign start_c   = aligned_reg - off_reg;
    assign user_c    = aligned_reg - aoff_reg;
    assign new_top_c = aligned_reg + delta_reg;
    assign fit_c     = !req_zero_reg && (new_top_c <= CW'(limit_reg));
    assign do_alloc  = (op_reg == asa_pkg::OP_ALLOC) && fit_c;

    always_comb begin
        top_next  = top_reg;
        granted_c = 1'b0;
        addr_c    = '0;
        case (op_reg)
            asa_pkg::OP_ALLOC: begin
                if (fit_c) begin
                    top_next  = new_top_c[DW-1:0];
                    granted_c = 1'b1;
                    addr_c    = user_c[DW-1:0];
                end
            end
            asa_pkg::OP_FREE: begin
                if (free_ok_reg) begin
                    top_next  = hdr_rd_reg;
                    granted_c = 1'b1;
                end
            end
            asa_pkg::OP_CLEAR: begin
                top_next  = '0;
                granted_c = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers: limit and stack top
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            top_reg   <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= (CW'(cfg_wdata) > BUF_LAST) ? DW'(BUFFER_BYTES) : cfg_wdata;
            end
            if (cmd.finish) begin
                top_reg <= top_next;
            end
        end
    end

    // Word capture at accept
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= s_operation;
            aligned_reg  <= sum_in & ~mask_in;
            off_reg      <= off_in;
            aoff_reg     <= CW'(s_align_offset);
            delta_reg    <= CW'(s_request_bytes) + HDR - off_in;
            req_zero_reg <= (s_request_bytes == '0);
            free_ok_reg  <= free_ok_in;
        end
    end

    // Header memory: read at accept, write on a successful allocate
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            hdr_rd_reg <= hdr_mem[rel_idx[AW-1:0]];
        end
        if (cmd.finish && do_alloc) begin
            hdr_mem[start_c[AW-1:0]] <= top_reg;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            addr_out_reg    <= addr_c;
            granted_out_reg <= granted_c;
            top_out_reg     <= top_next;
        end
    end

    assign m_granted_address = addr_out_reg;
    assign m_granted         = granted_out_reg;
    assign m_stack_top       = top_out_reg;

endmodule

// File: design/aligned_stack_allocator.sv
// Aligned stack allocator: bump allocation over a buffer, addresses as byte offsets.
// Each input word is an allocate, a deallocate or a reset of the stack top, and gives
// exactly one output word (granted address, granted flag, stack top after the
// operation). The accept step aligns the top and reads the header memory; the finish
// state then commits the new top and the header write and loads the output register,
// waiting while the output register holds a result not yet taken. A new word is
// accepted only once the previous one has left the finish state. The output register
// lets a new word be accepted while the previous result waits. The user must write
// buffer_size through cfg_we/cfg_wdata only while the block is idle; the block does
// not enforce this. Values above BUFFER_BYTES act as BUFFER_BYTES. The header memory
// is not cleared; deallocate must be given an address that allocate returned.
module aligned_stack_allocator #(
    parameter int BUFFER_BYTES = 4096,
    parameter int HEADER_BYTES = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [asa_pkg::ADDR_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [asa_pkg::OP_W-1:0]     s_operation,
    input  logic [asa_pkg::ADDR_W-1:0]   s_request_bytes,
    input  logic [asa_pkg::LOG2_W-1:0]   s_alignment_log2,
    input  logic [asa_pkg::AOFF_W-1:0]   s_align_offset,
    input  logic [asa_pkg::ADDR_W-1:0]   s_release_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [asa_pkg::ADDR_W-1:0]   m_granted_address,
    output logic                         m_granted,
    output logic [asa_pkg::ADDR_W-1:0]   m_stack_top
);

    asa_pkg::asa_cmd_t cmd;

    asa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    asa_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_operation       (s_operation),
        .s_request_bytes   (s_request_bytes),
        .s_alignment_log2  (s_alignment_log2),
        .s_align_offset    (s_align_offset),
        .s_release_address (s_release_address),
        .m_granted_address (m_granted_address),
        .m_granted         (m_granted),
        .m_stack_top       (m_stack_top)
    );

endmodule

// File: design/asa_checker.sv
module asa_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [asa_pkg::ADDR_W-1:0] m_granted_address,
    input logic                       m_granted,
    input logic [asa_pkg::ADDR_W-1:0] m_stack_top
);

    // Output word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_address)
            && $stable(m_granted) && $stable(m_stack_top))
        else $error("output word changed while stalled");

    // One word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // Failed words carry a zero address
    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> m_granted_address == '0)
        else $error("address given on a failed word");

    // A granted address lies below the new top
    a_block_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted && m_granted_address != '0 |-> m_stack_top > m_granted_address)
        else $error("granted block above stack top");

    // No output word right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_granted_address (m_granted_address),
    .m_granted         (m_granted),
    .m_stack_top       (m_stack_top)
);

// File: test/tb.sv
module tb;

    localparam int BUF_BYTES   = 4096;
    localparam int HDR_BYTES   = 4;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 6;

    // Word formats and operation codes of the block
    localparam int OP_W   = asa_pkg::OP_W;
    localparam int ADDR_W = asa_pkg::ADDR_W;
    localparam int LOG2_W = asa_pkg::LOG2_W;
    localparam int AOFF_W = asa_pkg::AOFF_W;
    localparam logic [OP_W-1:0] OP_ALLOC = asa_pkg::OP_ALLOC;
    localparam logic [OP_W-1:0] OP_FREE  = asa_pkg::OP_FREE;
    localparam logic [OP_W-1:0] OP_CLEAR = asa_pkg::OP_CLEAR;

    // Operation code the block has to ignore
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] nbytes;
        logic [LOG2_W-1:0] lg;
        logic [AOFF_W-1:0] aoff;
        logic [ADDR_W-1:0] rel;
    } alloc_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              granted;
        logic [ADDR_W-1:0] top;
    } alloc_resp_t;

    typedef struct packed {
        alloc_req_t  cmd;
        logic        typed;
        alloc_resp_t want;
    } dir_row_t;

    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              cfg_we            = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata         = '0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_operation       = '0;
    logic [ADDR_W-1:0] s_request_bytes   = '0;
    logic [LOG2_W-1:0] s_alignment_log2  = '0;
    logic [AOFF_W-1:0] s_align_offset    = '0;
    logic [ADDR_W-1:0] s_release_address = '0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic [ADDR_W-1:0] m_granted_address;
    logic              m_granted;
    logic [ADDR_W-1:0] m_stack_top;

    // Allocator mirror: size register, top, saved headers
    logic [ADDR_W-1:0] size_reg = asa_pkg::BUFFER_SIZE_RESET;
    logic [ADDR_W-1:0] top_mirror = '0;
    logic [ADDR_W-1:0] hdr_mirror [0:BUF_BYTES-1];
    int unsigned       live_q[$];     // user addresses of blocks still on the stack
    int unsigned       issued_q[$];   // every user address ever granted
    alloc_resp_t       due_resp_q[$];
    dir_row_t          dir_q[$];

    int errors = 0;
    int resp_count = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left = 0;

    aligned_stack_allocator #(
        .BUFFER_BYTES(BUF_BYTES),
        .HEADER_BYTES(HDR_BYTES)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_request_bytes   (s_request_bytes),
        .s_alignment_log2  (s_alignment_log2),
        .s_align_offset    (s_align_offset),
        .s_release_address (s_release_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_granted         (m_granted),
        .m_stack_top       (m_stack_top)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the mirror and return the word it should produce
    function automatic alloc_resp_t alloc_predict(alloc_req_t w);
        alloc_resp_t r;
        int unsigned lim, blk_size, off, mask, aligned, start, new_top;
        r = '0;
        lim = (size_reg > BUF_BYTES) ? BUF_BYTES : size_reg;
        case (w.op)
            OP_ALLOC: begin
                if (w.nbytes != 0) begin
                    blk_size = w.nbytes + HDR_BYTES;
                    off = w.aoff + HDR_BYTES;
                    mask = (32'd1 << w.lg) - 1;
                    aligned = (top_mirror + off + mask) & ~mask;
                    start = aligned - off;
                    new_top = start + blk_size;
                    if (new_top <= lim) begin
                        hdr_mirror[start] = top_mirror;
                        top_mirror = ADDR_W'(new_top);
                        r.addr = ADDR_W'(start + HDR_BYTES);
                        r.granted = 1'b1;
                        live_q.push_back(start + HDR_BYTES);
                        issued_q.push_back(start + HDR_BYTES);
                    end
                end
            end
            OP_FREE: begin
                // out-of-range release is ignored
                if (w.rel >= HDR_BYTES && w.rel - HDR_BYTES < BUF_BYTES) begin
                    top_mirror = hdr_mirror[w.rel - HDR_BYTES];
                    r.granted = 1'b1;
                end
            end
            OP_CLEAR: begin
                top_mirror = '0;
                r.granted = 1'b1;
            end
            default: ;
        endcase
        // blocks starting at or above the top are gone
        while (live_q.size() > 0 && live_q[$] - HDR_BYTES >= top_mirror)
            void'(live_q.pop_back());
        r.top = top_mirror;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("word %0d: %s got %0d expected %0d", resp_count, what, got, want);
        errors++;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input int unsigned nbytes,
                           input int unsigned lg, input int unsigned aoff,
                           input int unsigned rel, input logic typed,
                           input int unsigned addr, input logic granted,
                           input int unsigned top);
        dir_row_t r;
        r.cmd.op = op;
        r.cmd.nbytes = ADDR_W'(nbytes);
        r.cmd.lg = LOG2_W'(lg);
        r.cmd.aoff = AOFF_W'(aoff);
        r.cmd.rel = ADDR_W'(rel);
        r.typed = typed;
        r.want.addr = ADDR_W'(addr);
        r.want.granted = granted;
        r.want.top = ADDR_W'(top);
        dir_q.push_back(r);
    endtask

    // Present one word, hold it until taken, then queue its expected result
    task automatic send_word(input alloc_req_t w, input logic typed,
                             input alloc_resp_t want);
        alloc_resp_t predicted;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= w.op;
        s_request_bytes   <= w.nbytes;
        s_alignment_log2  <= w.lg;
        s_align_offset    <= w.aoff;
        s_release_address <= w.rel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = alloc_predict(w);
        due_resp_q.push_back(typed ? want : predicted);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        s_valid <= 1'b0;
        while (due_resp_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(input logic [ADDR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        size_reg = v;
    endtask

    // Result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge aclk) begin : out_check
        alloc_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_resp_q.size() == 0) begin
                flag_mismatch("unexpected word, stack_top", m_stack_top, 0);
            end else begin
                want = due_resp_q.pop_front();
                if (m_granted_address !== want.addr)
                    flag_mismatch("granted_address", m_granted_address, want.addr);
                if (m_granted !== want.granted)
                    flag_mismatch("granted", m_granted, want.granted);
                if (m_stack_top !== want.top)
                    flag_mismatch("stack_top", m_stack_top, want.top);
            end
            resp_count++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", due_resp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        alloc_req_t  w;
        alloc_resp_t none;
        int unsigned pick;
        int unsigned ph_size [N_PHASES];
        int unsigned ph_count [N_PHASES];
        int unsigned ph_send [N_PHASES];
        int unsigned ph_recv [N_PHASES];

        none = '0;
        ph_size  = '{4096, 8191, 0, 300, 0, 4096};
        ph_count = '{200, 150, 40, 150, 150, 110};
        ph_send  = '{20, 0, 30, 10, 40, 0};
        ph_recv  = '{0, 25, 30, 10, 40, 0};
        ph_size[4] = $urandom_range(16, 4096);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words on the reset size; typed results where obvious
        add_row(OP_ALLOC, 0, 0, 0, 0, 1, 0, 0, 0);             // zero size
        add_row(OP_FREE, 0, 0, 0, 0, 1, 0, 0, 0);              // release below header
        add_row(OP_FREE, 0, 0, 0, 8191, 1, 0, 0, 0);           // release far past buffer
        add_row(OP_NONE, 8191, 15, 4095, 8191, 1, 0, 0, 0);    // unknown op
        add_row(OP_ALLOC, 8191, 0, 0, 0, 1, 0, 0, 0);          // no fit
        add_row(OP_ALLOC, 4092, 0, 0, 0, 1, 4, 1, 4096);       // exact fit
        add_row(OP_ALLOC, 1, 0, 0, 0, 1, 0, 0, 4096);          // full buffer
        add_row(OP_FREE, 0, 0, 0, 4, 1, 0, 1, 0);
        add_row(OP_FREE, 0, 0, 0, 4100, 1, 0, 0, 0);           // header just past buffer
        add_row(OP_FREE, 0, 0, 0, 3, 1, 0, 0, 0);
        add_row(OP_ALLOC, 12, 0, 0, 0, 1, 4, 1, 16);
        add_row(OP_ALLOC, 20, 4, 0, 0, 0, 0, 0, 0);
        add_row(OP_ALLOC, 100, 12, 4095, 0, 0, 0, 0, 0);
        add_row(OP_ALLOC, 5, 3, 6, 0, 0, 0, 0, 0);
        add_row(OP_ALLOC, 1, 15, 0, 0, 0, 0, 0, 0);             // alignment beyond buffer
        add_row(OP_ALLOC, 1, 13, 4095, 0, 0, 0, 0, 0);
        add_row(OP_FREE, 0, 0, 0, 58, 0, 0, 0, 0);
        add_row(OP_FREE, 0, 0, 0, 32, 0, 0, 0, 0);
        add_row(OP_CLEAR, 0, 0, 0, 0, 1, 0, 1, 0);
        add_row(OP_ALLOC, 4095, 0, 0, 0, 1, 0, 0, 0);
        add_row(OP_ALLOC, 8, 12, 4092, 0, 0, 0, 0, 0);
        add_row(OP_FREE, 0, 0, 0, 4, 0, 0, 0, 0);

        send_idle_pct = 15;
        recv_idle_pct = 15;
        foreach (dir_q[i])
            send_word(dir_q[i].cmd, dir_q[i].typed, dir_q[i].want);

        // Random phases, each on its own buffer size, written while idle
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            send_idle_pct = ph_send[ph];
            recv_idle_pct = ph_recv[ph];
            write_size(ADDR_W'(ph_size[ph]));
            for (int n = 0; n < ph_count[ph]; n++) begin
                pick = $urandom_range(0, 99);
                w.op     = OP_ALLOC;
                w.nbytes = ADDR_W'($urandom_range(1, 128));
                w.lg     = LOG2_W'($urandom_range(0, 6));
                w.aoff   = AOFF_W'($urandom_range(0, 15));
                w.rel    = ADDR_W'($urandom);
                if (pick < 8) begin
                    // any field value, mostly no fit
                    w.nbytes = ADDR_W'($urandom);
                    w.lg     = LOG2_W'($urandom);
                    w.aoff   = AOFF_W'($urandom);
                end else if (pick < 18) begin
                    w.nbytes = ADDR_W'($urandom_range(1, 1024));
                    w.lg     = LOG2_W'($urandom_range(0, 12));
                    w.aoff   = AOFF_W'($urandom);
                end else if (pick < 21) begin
                    w.nbytes = '0;
                end else if (pick < 46) begin
                    // mostly free the newest block, sometimes an older one
                    w.op = OP_FREE;
                    if (live_q.size() > 0 && $urandom_range(0, 9) != 0)
                        w.rel = ADDR_W'(live_q[$]);
                    else if (issued_q.size() > 0)
                        w.rel = ADDR_W'(issued_q[$urandom_range(0, issued_q.size() - 1)]);
                    else
                        w.rel = ADDR_W'($urandom_range(0, 3));
                end else if (pick < 49) begin
                    w.op = OP_CLEAR;
                end else if (pick < 52) begin
                    w.op = OP_NONE;
                end else if (pick < 56) begin
                    w.op = OP_FREE;
                    if ($urandom_range(0, 1) == 0)
                        w.rel = ADDR_W'($urandom_range(0, 3));
                    else
                        w.rel = ADDR_W'($urandom_range(4100, 8191));
                end
                send_word(w, 1'b0, none);
                // hold off once mid-phase until everything is back
                if (ph == 0 && n == 100)
                    drain();
            end
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
design/asa_pkg.sv
design/asa_ctrl.sv
design/asa_datapath.sv
design/aligned_stack_allocator.sv
design/asa_checker.sv
test/tb.sv
